// ===== rtl/core/spl_pkg.sv =====
// Package for the sorted priority list: sizes, command codes and the cell bus types.
// No dependencies.
package spl_pkg;
  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned NUM_CURSORS = 4;
  localparam int unsigned POS_W       = $clog2(CAPACITY + 1);
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 3;

  localparam logic [ADDR_W-1:0] ADDR_ORDERED  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_DISABLED = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEAD_INS = 3'd0,
    CMD_SORT_INS = 3'd1,
    CMD_DELETE   = 3'd2,
    CMD_LOOKUP   = 3'd3,
    CMD_CUR_FIRST = 3'd4,
    CMD_CUR_NEXT = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_APPLY
  } state_e;

  // Broadcast from control to every cell.
  typedef struct packed {
    cell_op_e           op;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  id;
    logic [DATA_W-1:0]  pri;
  } cell_ctl_t;

  // Per-cell status flags back to control.
  typedef struct packed {
    logic id_hit;
    logic pri_ge;
  } cell_stat_t;
endpackage

// ===== rtl/core/spl_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on spl_pkg.
interface spl_in_if;
  logic                      valid;
  logic                      ready;
  logic [spl_pkg::CMD_W-1:0]  cmd;
  logic [spl_pkg::DATA_W-1:0] entry_id;
  logic [spl_pkg::DATA_W-1:0] entry_priority;
  logic [spl_pkg::SEL_W-1:0]  cursor_sel;
  modport source (output valid, cmd, entry_id, entry_priority, cursor_sel, input ready);
  modport sink (input valid, cmd, entry_id, entry_priority, cursor_sel, output ready);
endinterface

interface spl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [spl_pkg::DATA_W-1:0] id_out;
  logic [spl_pkg::DATA_W-1:0] priority_out;
  modport source (output valid, ok, id_out, priority_out, input ready);
  modport sink (input valid, ok, id_out, priority_out, output ready);
endinterface

// ===== rtl/core/sorted_priority_list_with_cursors.sv =====
// Sorted priority list with cursors: an item is accepted, its flags settle
// in the cell row, and the next cycle applies it and registers its result.
// No item is taken during the compare-then-shift step of the last one.
// A held result stalls input.
// Async active-low reset empties the list, nulls all cursors and clears
// both configuration registers; entry contents are not reset.
module sorted_priority_list_with_cursors (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  spl_in_if.sink                      in_ch,
  spl_out_if.source                   out_ch
);
  import spl_pkg::*;

  logic ordered_q, disabled_q;
  cell_ctl_t ctl;
  cell_stat_t stat [CAPACITY];
  logic [DATA_W-1:0] cid [CAPACITY];
  logic [DATA_W-1:0] cpri [CAPACITY];

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ordered_q  <= 1'b0;
      disabled_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        ADDR_ORDERED:  ordered_q  <= pwdata[0];
        ADDR_DISABLED: disabled_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_ORDERED:  prdata = {31'd0, ordered_q};
      ADDR_DISABLED: prdata = {31'd0, disabled_q};
      default:       prdata = '0;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spl_cell u_cell (
      .clk_i      (clk_i),
      .index_i    (POS_W'(g)),
      .ctl_i      (ctl),
      .prev_id_i  ((g == 0) ? cid[0] : cid[(g == 0) ? 0 : g - 1]),
      .prev_pri_i ((g == 0) ? cpri[0] : cpri[(g == 0) ? 0 : g - 1]),
      .next_id_i  (cid[(g == CAPACITY - 1) ? g : g + 1]),
      .next_pri_i (cpri[(g == CAPACITY - 1) ? g : g + 1]),
      .id_o       (cid[g]),
      .pri_o      (cpri[g]),
      .stat_o     (stat[g])
    );
  end

  spl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ordered_i  (ordered_q),
    .disabled_i (disabled_q),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .stat_i     (stat),
    .cell_id_i  (cid),
    .cell_pri_i (cpri),
    .ctl_o      (ctl)
  );

`ifndef SYNTH
  // The input is refused while an accepted item is being applied.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !(in_ch.ready))
    else $error("ready high during apply cycle");
  a_result_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> ##1 out_ch.valid)
    else $error("result missing after item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.ok)))
    else $error("result dropped while stalled");
`endif
endmodule

// ===== rtl/core/spl_cell.sv =====
// One list cell: holds an entry, compares it to the broadcast key, and shifts
// with its neighbors on insert or remove. Depends on spl_pkg.
module spl_cell (
  input  logic                       clk_i,
  input  logic [spl_pkg::POS_W-1:0]  index_i,
  input  spl_pkg::cell_ctl_t         ctl_i,
  input  logic [spl_pkg::DATA_W-1:0] prev_id_i,
  input  logic [spl_pkg::DATA_W-1:0] prev_pri_i,
  input  logic [spl_pkg::DATA_W-1:0] next_id_i,
  input  logic [spl_pkg::DATA_W-1:0] next_pri_i,
  output logic [spl_pkg::DATA_W-1:0] id_o,
  output logic [spl_pkg::DATA_W-1:0] pri_o,
  output spl_pkg::cell_stat_t        stat_o
);
  import spl_pkg::*;

  logic [DATA_W-1:0] id_q, id_d, pri_q, pri_d;

  always_comb begin
    id_d  = id_q;
    pri_d = pri_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (index_i == ctl_i.pos) begin
          id_d  = ctl_i.id;
          pri_d = ctl_i.pri;
        end else if (index_i > ctl_i.pos) begin
          id_d  = prev_id_i;
          pri_d = prev_pri_i;
        end
      end
      OP_REMOVE: begin
        if (index_i >= ctl_i.pos) begin
          id_d  = next_id_i;
          pri_d = next_pri_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    pri_q <= pri_d;
  end

  assign id_o          = id_q;
  assign pri_o         = pri_q;
  assign stat_o.id_hit = (id_q == ctl_i.id);
  assign stat_o.pri_ge = (pri_q >= ctl_i.pri);
endmodule

// ===== rtl/core/spl_ctrl.sv =====
// Command sequencer: finds positions from the cell flags, updates count and
// cursors, drives the cell ops and the result register. Depends on spl_pkg.
module spl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ordered_i,
  input  logic                          disabled_i,
  spl_in_if.sink                        in_ch,
  spl_out_if.source                     out_ch,
  input  spl_pkg::cell_stat_t           stat_i [spl_pkg::CAPACITY],
  input  logic [spl_pkg::DATA_W-1:0]    cell_id_i [spl_pkg::CAPACITY],
  input  logic [spl_pkg::DATA_W-1:0]    cell_pri_i [spl_pkg::CAPACITY],
  output spl_pkg::cell_ctl_t            ctl_o
);
  import spl_pkg::*;

  localparam logic [POS_W-1:0] NULL_POS = POS_W'(CAPACITY);
  localparam int unsigned IDX_W = $clog2(CAPACITY);

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] key_id_q, key_pri_q;
  logic [SEL_W-1:0]  sel_q;
  logic [POS_W-1:0]  count_q, count_d;
  logic [POS_W-1:0]  cur_q [NUM_CURSORS];
  logic [POS_W-1:0]  cur_d [NUM_CURSORS];
  logic              rvalid_q, rvalid_d;
  logic              rok_q, rok_d;
  logic [DATA_W-1:0] rid_q, rid_d, rpri_q, rpri_d;

  logic [POS_W-1:0]  hit_pos, ge_pos, ins_pos;
  logic              sel_valid;
  logic [POS_W-1:0]  cp;

  // Lowest-index matching cell wins; cells beyond count are ignored.
  always_comb begin
    hit_pos = NULL_POS;
    ge_pos  = count_q;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (POS_W'(i) < count_q && stat_i[i].id_hit) hit_pos = POS_W'(i);
      if (POS_W'(i) < count_q && stat_i[i].pri_ge) ge_pos = POS_W'(i);
    end
  end

  assign sel_valid = (32'(sel_q) < NUM_CURSORS);
  assign cp        = cur_q[sel_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_ch.valid && in_ch.ready) state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_q == ST_IDLE) && (!rvalid_q || out_ch.ready);

  always_comb begin
    logic [POS_W-1:0] np;
    np       = NULL_POS;
    count_d  = count_q;
    cur_d    = cur_q;
    ins_pos  = '0;
    rok_d    = rok_q;
    rid_d    = rid_q;
    rpri_d   = rpri_q;
    rvalid_d = rvalid_q && !out_ch.ready;
    ctl_o.op  = OP_HOLD;
    ctl_o.pos = '0;
    ctl_o.id  = (state_q == ST_IDLE) ? in_ch.entry_id : key_id_q;
    ctl_o.pri = (state_q == ST_IDLE) ? in_ch.entry_priority : key_pri_q;
    if (state_q == ST_APPLY) begin
      rvalid_d = 1'b1;
      rok_d    = 1'b0;
      rid_d    = '0;
      rpri_d   = '0;
      case (cmd_q)
        CMD_HEAD_INS, CMD_SORT_INS: begin
          ins_pos = (cmd_q == CMD_SORT_INS && ordered_i) ? ge_pos : '0;
          if (count_q < NULL_POS) begin
            rok_d     = 1'b1;
            count_d   = count_q + 1'b1;
            ctl_o.op  = OP_INSERT;
            ctl_o.pos = ins_pos;
            if (!(cmd_q == CMD_SORT_INS && ordered_i)) ctl_o.pri = '0;
            for (int c = 0; c < NUM_CURSORS; c++)
              if (cur_q[c] < NULL_POS && cur_q[c] >= ins_pos) cur_d[c] = cur_q[c] + 1'b1;
          end
        end
        CMD_DELETE: begin
          if (hit_pos < NULL_POS) begin
            rok_d     = 1'b1;
            count_d   = count_q - 1'b1;
            ctl_o.op  = OP_REMOVE;
            ctl_o.pos = hit_pos;
            for (int c = 0; c < NUM_CURSORS; c++) begin
              if (cur_q[c] < NULL_POS) begin
                np = (cur_q[c] > hit_pos) ? cur_q[c] - 1'b1 : cur_q[c];
                cur_d[c] = (np >= count_d) ? NULL_POS : np;
              end
            end
          end
        end
        CMD_LOOKUP: begin
          if (hit_pos < NULL_POS) begin
            rok_d  = 1'b1;
            rpri_d = cell_pri_i[hit_pos[IDX_W-1:0]];
          end
        end
        CMD_CUR_FIRST, CMD_CUR_NEXT: begin
          if (!disabled_i && sel_valid && !(cmd_q == CMD_CUR_NEXT && cp >= NULL_POS)) begin
            if (cmd_q == CMD_CUR_FIRST) np = (count_q != '0) ? '0 : NULL_POS;
            else np = (cp + 1'b1 >= count_q) ? NULL_POS : cp + 1'b1;
            for (int c = 0; c < NUM_CURSORS; c++)
              if (32'(sel_q) == c) cur_d[c] = np;
            if (np < NULL_POS) begin
              rok_d  = 1'b1;
              rid_d  = cell_id_i[np[IDX_W-1:0]];
              rpri_d = cell_pri_i[np[IDX_W-1:0]];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      for (int c = 0; c < NUM_CURSORS; c++) cur_q[c] <= NULL_POS;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      cur_q    <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_q     <= in_ch.cmd;
      key_id_q  <= in_ch.entry_id;
      key_pri_q <= in_ch.entry_priority;
      sel_q     <= in_ch.cursor_sel;
    end
    rok_d_reg: begin
      rok_q  <= rok_d;
      rid_q  <= rid_d;
      rpri_q <= rpri_d;
    end
  end

  assign out_ch.valid        = rvalid_q;
  assign out_ch.ok           = rok_q;
  assign out_ch.id_out       = rid_q;
  assign out_ch.priority_out = rpri_q;
endmodule

// ===== dv/tb_sorted_priority_list_with_cursors.sv =====
// Testbench for the sorted priority list with cursors: directed table plus random
// commands, checked against a behavioral model of the list. Depends on spl_pkg, spl_if.
`timescale 1ns / 100ps
module tb_sorted_priority_list_with_cursors;
  import spl_pkg::*;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] id;
    logic [31:0] pri;
    logic [1:0]  sel;
  } cmd_item_t;

  typedef struct {
    logic        ok;
    logic [31:0] id;
    logic [31:0] pri;
  } answer_t;

  typedef struct {
    cmd_item_t item;
    bit        known;
    answer_t   ans;
  } table_row_t;

  localparam int unsigned NULL_POS = CAPACITY;
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  spl_in_if in_ch();
  spl_out_if out_ch();

  sorted_priority_list_with_cursors i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // Behavioral copy of the list.
  logic [31:0] m_id [CAPACITY];
  logic [31:0] m_pri [CAPACITY];
  int unsigned m_count;
  int unsigned m_cur [NUM_CURSORS];
  bit m_ordered, m_disabled;

  answer_t answers_due[$];
  int errors = 0;
  int cfg_phase = 0;
  bit rx_hold = 1'b0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;
  int unsigned ids_used[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit list_place(int unsigned pos, logic [31:0] id, logic [31:0] pri);
    if (m_count >= CAPACITY || pos > m_count) return 0;
    for (int i = m_count; i > pos; i--) begin
      m_id[i] = m_id[i-1];
      m_pri[i] = m_pri[i-1];
    end
    m_id[pos] = id;
    m_pri[pos] = pri;
    m_count++;
    for (int c = 0; c < NUM_CURSORS; c++)
      if (m_cur[c] < NULL_POS && m_cur[c] >= pos) m_cur[c]++;
    return 1;
  endfunction

  function automatic int unsigned list_find(logic [31:0] id);
    for (int i = 0; i < m_count; i++)
      if (m_id[i] == id) return i;
    return NULL_POS;
  endfunction

  function automatic answer_t list_apply(cmd_item_t it);
    answer_t a;
    int unsigned pos;
    a = '{1'b0, 32'd0, 32'd0};
    case (it.cmd)
      CMD_HEAD_INS: a.ok = list_place(0, it.id, 0);
      CMD_SORT_INS: begin
        if (!m_ordered) a.ok = list_place(0, it.id, 0);
        else begin
          pos = m_count;
          for (int i = 0; i < m_count; i++)
            if (m_pri[i] >= it.pri) begin
              pos = i;
              break;
            end
          a.ok = list_place(pos, it.id, it.pri);
        end
      end
      CMD_DELETE: begin
        pos = list_find(it.id);
        if (pos < NULL_POS) begin
          for (int i = pos; i + 1 < m_count; i++) begin
            m_id[i] = m_id[i+1];
            m_pri[i] = m_pri[i+1];
          end
          m_count--;
          for (int c = 0; c < NUM_CURSORS; c++)
            if (m_cur[c] < NULL_POS) begin
              if (m_cur[c] > pos) m_cur[c]--;
              if (m_cur[c] >= m_count) m_cur[c] = NULL_POS;
            end
          a.ok = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        pos = list_find(it.id);
        if (pos < NULL_POS) begin
          a.ok = 1'b1;
          a.pri = m_pri[pos];
        end
      end
      CMD_CUR_FIRST, CMD_CUR_NEXT: begin
        if (!m_disabled && it.sel < NUM_CURSORS) begin
          pos = NULL_POS;
          if (it.cmd == CMD_CUR_FIRST) begin
            if (m_count > 0) pos = 0;
            m_cur[it.sel] = pos;
          end else if (m_cur[it.sel] < NULL_POS) begin
            pos = m_cur[it.sel] + 1;
            if (pos >= m_count) pos = NULL_POS;
            m_cur[it.sel] = pos;
          end
          if (pos < NULL_POS) begin
            a.ok = 1'b1;
            a.id = m_id[pos];
            a.pri = m_pri[pos];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_ORDERED) m_ordered = data[0];
    else m_disabled = data[0];
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (answers_due.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Drives one item; the caller's expectation, if any, is checked against the model.
  // Valid stays high after an acceptance so that the next item can follow at once.
  task automatic send(cmd_item_t it, bit known, answer_t want);
    answer_t a;
    if (!tx_calm && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 25) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.entry_id <= it.id;
    in_ch.entry_priority <= it.pri;
    in_ch.cursor_sel <= it.sel;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    a = list_apply(it);
    if (known && a != want) begin
      $display("directed row disagrees with model: cmd %0d", it.cmd);
      errors++;
    end
    answers_due.push_back(a);
  endtask

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int r;
    r = $urandom_range(99);
    it.sel = 2'($urandom);
    it.pri = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
    if ($urandom_range(9) == 0 || ids_used.size() == 0) it.id = $urandom;
    else it.id = ids_used[$urandom_range(ids_used.size() - 1)];
    if (r < 20) it.cmd = CMD_HEAD_INS;
    else if (r < 45) it.cmd = CMD_SORT_INS;
    else if (r < 58) it.cmd = CMD_DELETE;
    else if (r < 68) it.cmd = CMD_LOOKUP;
    else if (r < 76) it.cmd = CMD_CUR_FIRST;
    else if (r < 97) it.cmd = CMD_CUR_NEXT;
    else it.cmd = 3'($urandom_range(CMD_UNUSED7, CMD_UNUSED6));
    return it;
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    answer_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (answers_due.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_ch.ok !== want.ok) report("ok", out_ch.ok, want.ok);
        if (out_ch.id_out !== want.id) report("id_out", out_ch.id_out, want.id);
        if (out_ch.priority_out !== want.pri) report("priority_out", out_ch.priority_out, want.pri);
      end
    end
    out_ch.ready <= !rx_hold && (rx_calm || $urandom_range(99) >= 25);
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    table_row_t rows[$];
    cmd_item_t it;
    answer_t none;
    none = '{1'b0, 32'd0, 32'd0};
    in_ch.valid = 1'b0; in_ch.cmd = '0; in_ch.entry_id = '0;
    in_ch.entry_priority = '0; in_ch.cursor_sel = '0;
    out_ch.ready = 1'b0;
    m_count = 0; m_ordered = 0; m_disabled = 0;
    for (int c = 0; c < NUM_CURSORS; c++) m_cur[c] = NULL_POS;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // After reset: empty list, null cursors.
    rows.push_back('{'{CMD_CUR_FIRST, '0, '0, 2'd0}, 1'b1, none});
    rows.push_back('{'{CMD_CUR_NEXT, '0, '0, 2'd3}, 1'b1, none});
    rows.push_back('{'{CMD_LOOKUP, 32'hFFFF_FFFF, '0, 2'd0}, 1'b1, none});
    rows.push_back('{'{CMD_DELETE, '0, '0, 2'd0}, 1'b1, none});
    rows.push_back('{'{CMD_HEAD_INS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0}, 1'b1,
                     '{1'b1, '0, '0}});
    rows.push_back('{'{CMD_HEAD_INS, '0, '0, 2'd0}, 1'b1, '{1'b1, '0, '0}});
    rows.push_back('{'{CMD_CUR_FIRST, '0, '0, 2'd1}, 1'b1, '{1'b1, '0, '0}});
    rows.push_back('{'{CMD_CUR_NEXT, '0, '0, 2'd1}, 1'b1, '{1'b1, 32'hFFFF_FFFF, '0}});
    rows.push_back('{'{CMD_CUR_NEXT, '0, '0, 2'd1}, 1'b1, none});
    rows.push_back('{'{CMD_UNUSED6, 32'd5, 32'd5, 2'd0}, 1'b1, none});
    rows.push_back('{'{CMD_UNUSED7, 32'd5, 32'd5, 2'd0}, 1'b1, none});
    rows.push_back('{'{CMD_SORT_INS, 32'd7, 32'd9, 2'd2}, 1'b0, none});
    rows.push_back('{'{CMD_CUR_FIRST, '0, '0, 2'd2}, 1'b0, none});
    rows.push_back('{'{CMD_DELETE, 32'd7, '0, 2'd0}, 1'b0, none});
    rows.push_back('{'{CMD_CUR_NEXT, '0, '0, 2'd2}, 1'b0, none});
    rows.push_back('{'{CMD_DELETE, 32'hFFFF_FFFF, '0, 2'd0}, 1'b1, '{1'b1, '0, '0}});
    foreach (rows[i]) send(rows[i].item, rows[i].known, rows[i].ans);
    drain();

    cfg_write(ADDR_ORDERED, 32'd1);
    for (int i = 0; i < 18; i++) begin
      it = '{CMD_SORT_INS, $urandom, (i == 3) ? 32'hFFFF_FFFF : $urandom_range(20), 2'(i)};
      ids_used.push_back(it.id);
      send(it, 1'b0, none);
    end
    send('{CMD_LOOKUP, ids_used[3], '0, 2'd0}, 1'b1, '{1'b1, '0, 32'hFFFF_FFFF});
    drain();

    for (int n = 0; n < 1200; n++) begin
      if (n % 150 == 0) begin
        drain();
        cfg_phase++;
        cfg_write(ADDR_ORDERED, $urandom_range(1));
        cfg_write(ADDR_DISABLED, (cfg_phase % 4 == 2) ? 32'd1 : 32'd0);
      end
      rx_calm = (n >= 600 && n < 750);
      tx_calm = rx_calm || (n >= 300 && n < 340);
      if (n == 300) rx_hold = 1'b1;
      if (n == 340) begin
        rx_hold = 1'b0;
        drain();
      end
      if (n == 500) drain();
      it = rand_item();
      if (it.cmd inside {CMD_HEAD_INS, CMD_SORT_INS}) begin
        ids_used.push_back(it.id);
        if (ids_used.size() > 24) void'(ids_used.pop_front());
      end
      send(it, 1'b0, none);
    end
    rx_hold = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // The long receiver hold-off is counted here while the sender keeps offering.
  initial begin
    wait (rx_hold);
    repeat (200) @(posedge clk_i);
    rx_hold = 1'b0;
  end
endmodule
